// File: rtl/complex_arithmetic_unit_macros.svh
// ---------------------------------------------------------------------------
// Complex arithmetic unit: assertion macros
// Shared property wrappers for the clocked checks in the RTL.
// ---------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// same-cycle implication
`define CAU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cau_pkg.sv
// ---------------------------------------------------------------------------
// Complex arithmetic unit package
// Widths, command codes, pipeline word types and the saturation function.
// ---------------------------------------------------------------------------
package cau_pkg;

    localparam int WORD_BITS     = 32;
    localparam int FRACTION_BITS = 16;
    localparam int PROD_W        = 2 * WORD_BITS;
    localparam int SUM_W         = PROD_W + 1;
    localparam int MAG_W         = PROD_W;
    localparam int QB            = WORD_BITS + 1;
    localparam int PRE_SH        = QB - FRACTION_BITS;
    localparam int CMD_W         = 2;

    localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 2'd3;

    localparam logic [MAG_W-1:0] POS_LIM = (MAG_W'(1) << (WORD_BITS - 1)) - MAG_W'(1);

    typedef struct packed {
        logic [CMD_W-1:0]            cmd;
        logic signed [WORD_BITS-1:0] a_real;
        logic signed [WORD_BITS-1:0] a_imag;
        logic signed [WORD_BITS-1:0] b_real;
        logic signed [WORD_BITS-1:0] b_imag;
    } t_op;

    typedef struct packed {
        logic                        is_div;
        logic                        dz;
        logic                        ovf;
        logic signed [WORD_BITS-1:0] re;
        logic signed [WORD_BITS-1:0] im;
        logic [MAG_W-1:0]            den;
        logic                        re_neg;
        logic                        im_neg;
        logic                        re_sat;
        logic                        im_sat;
        logic [MAG_W-1:0]            re_rem;
        logic [MAG_W-1:0]            im_rem;
        logic [QB-1:0]               re_nq;
        logic [QB-1:0]               im_nq;
    } t_lane;

    typedef struct packed {
        logic [WORD_BITS-1:0] val;
        logic                 ovf;
    } t_fin;

    function automatic t_fin f_finish(input logic neg, input logic [MAG_W-1:0] mag);
        t_fin             r;
        logic [MAG_W-1:0] lim;
        logic [MAG_W-1:0] m;
        lim   = neg ? POS_LIM + MAG_W'(1) : POS_LIM;
        r.ovf = (mag > lim);
        m     = r.ovf ? lim : mag;
        r.val = WORD_BITS'(neg ? (MAG_W'(0) - m) : m);
        return r;
    endfunction

endpackage

// File: rtl/cau_div_cell.sv
// ---------------------------------------------------------------------------
// Complex arithmetic unit: divider cell
// One restoring quotient bit for the real and imaginary lanes per cell.
// ---------------------------------------------------------------------------
module cau_div_cell
    import cau_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_lane i_lane,
    output logic  o_valid,
    output t_lane o_lane
);

    logic  r_valid;
    t_lane r_lane;
    t_lane n_lane;
    logic [MAG_W:0] re_sh;
    logic [MAG_W:0] im_sh;
    logic           re_ge;
    logic           im_ge;

    always_comb begin
        n_lane = i_lane;
        re_sh  = {i_lane.re_rem, i_lane.re_nq[QB-1]};
        im_sh  = {i_lane.im_rem, i_lane.im_nq[QB-1]};
        re_ge  = (re_sh >= {1'b0, i_lane.den});
        im_ge  = (im_sh >= {1'b0, i_lane.den});
        n_lane.re_rem = MAG_W'(re_ge ? re_sh - {1'b0, i_lane.den} : re_sh);
        n_lane.im_rem = MAG_W'(im_ge ? im_sh - {1'b0, i_lane.den} : im_sh);
        n_lane.re_nq  = {i_lane.re_nq[QB-2:0], re_ge};
        n_lane.im_nq  = {i_lane.im_nq[QB-2:0], im_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

// File: rtl/cau_front.sv
// ---------------------------------------------------------------------------
// Complex arithmetic unit: front end
// Operand register, products, sums and divider setup.
// ---------------------------------------------------------------------------
module cau_front
    import cau_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_op   i_op,
    output logic  o_valid,
    output t_lane o_lane
);

    // stage 1: operands
    logic r1_v;
    t_op  r1_op;

    // stage 2: products and add/sub
    logic                     r2_v;
    logic [CMD_W-1:0]         r2_cmd;
    logic signed [PROD_W-1:0] r2_prr, r2_pii, r2_pri, r2_pir, r2_sbr, r2_sbi;
    logic signed [WORD_BITS:0] r2_sre, r2_sim;

    // stage 3: sign/magnitude
    logic                      r3_v;
    logic [CMD_W-1:0]          r3_cmd;
    logic signed [WORD_BITS:0] r3_sre, r3_sim;
    logic                      r3_re_neg, r3_im_neg;
    logic [MAG_W-1:0]          r3_re_mag, r3_im_mag, r3_den;

    // stage 4
    logic  r4_v;
    t_lane r4_lane;

    logic signed [WORD_BITS:0] n_sre, n_sim;
    logic signed [SUM_W-1:0]   s_re, s_im;
    logic [SUM_W-1:0]          m_re, m_im;
    logic [WORD_BITS:0]        a_re, a_im;
    t_fin                      f_re, f_im;
    t_lane                     n_lane;

    always_comb begin
        if (r1_op.cmd == CMD_SUB) begin
            n_sre = r1_op.a_real - r1_op.b_real;
            n_sim = r1_op.a_imag - r1_op.b_imag;
        end else begin
            n_sre = r1_op.a_real + r1_op.b_real;
            n_sim = r1_op.a_imag + r1_op.b_imag;
        end
    end

    always_comb begin
        if (r2_cmd == CMD_MUL) begin
            s_re = r2_prr - r2_pii;
            s_im = r2_pri + r2_pir;
        end else begin
            s_re = r2_prr + r2_pii;
            s_im = r2_pir - r2_pri;
        end
        m_re = s_re[SUM_W-1] ? -s_re : s_re;
        m_im = s_im[SUM_W-1] ? -s_im : s_im;
    end

    always_comb begin
        n_lane        = '0;
        n_lane.is_div = (r3_cmd == CMD_DIV);
        n_lane.den    = r3_den;
        n_lane.re_neg = r3_re_neg;
        n_lane.im_neg = r3_im_neg;
        n_lane.dz     = (r3_cmd == CMD_DIV) && (r3_den == '0);
        n_lane.re_sat = ((r3_re_mag >> PRE_SH) >= r3_den);
        n_lane.im_sat = ((r3_im_mag >> PRE_SH) >= r3_den);
        n_lane.re_rem = r3_re_mag >> PRE_SH;
        n_lane.im_rem = r3_im_mag >> PRE_SH;
        n_lane.re_nq  = QB'(r3_re_mag[QB-1:0] << FRACTION_BITS);
        n_lane.im_nq  = QB'(r3_im_mag[QB-1:0] << FRACTION_BITS);
        a_re = r3_sre[WORD_BITS] ? -r3_sre : r3_sre;
        a_im = r3_sim[WORD_BITS] ? -r3_sim : r3_sim;
        if (r3_cmd == CMD_MUL) begin
            f_re = f_finish(r3_re_neg, r3_re_mag >> FRACTION_BITS);
            f_im = f_finish(r3_im_neg, r3_im_mag >> FRACTION_BITS);
        end else begin
            f_re = f_finish(r3_sre[WORD_BITS], MAG_W'(a_re));
            f_im = f_finish(r3_sim[WORD_BITS], MAG_W'(a_im));
        end
        n_lane.re  = f_re.val;
        n_lane.im  = f_im.val;
        n_lane.ovf = f_re.ovf | f_im.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_op     <= i_op;
            r2_cmd    <= r1_op.cmd;
            r2_prr    <= r1_op.a_real * r1_op.b_real;
            r2_pii    <= r1_op.a_imag * r1_op.b_imag;
            r2_pri    <= r1_op.a_real * r1_op.b_imag;
            r2_pir    <= r1_op.a_imag * r1_op.b_real;
            r2_sbr    <= r1_op.b_real * r1_op.b_real;
            r2_sbi    <= r1_op.b_imag * r1_op.b_imag;
            r2_sre    <= n_sre;
            r2_sim    <= n_sim;
            r3_cmd    <= r2_cmd;
            r3_sre    <= r2_sre;
            r3_sim    <= r2_sim;
            r3_re_neg <= s_re[SUM_W-1];
            r3_im_neg <= s_im[SUM_W-1];
            r3_re_mag <= m_re[MAG_W-1:0];
            r3_im_mag <= m_im[MAG_W-1:0];
            r3_den    <= MAG_W'($unsigned(r2_sbr)) + MAG_W'($unsigned(r2_sbi));
            r4_lane   <= n_lane;
        end
    end

    assign o_valid = r4_v;
    assign o_lane  = r4_lane;

endmodule

// File: rtl/complex_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined complex add, subtract, multiply and divide on signed Q16.16.
// ---------------------------------------------------------------------------
// Input channel i_valid/o_ready carries a command and two complex operands;
// output channel o_valid/i_ready carries the result word with the
// divide-by-zero and overflow flags.
// One word enters per cycle and one result leaves per cycle while i_ready
// is high. From input accept to o_valid a word passes the operand register,
// multiply, sum, divider setup, one cell per quotient bit (33 cells), and
// the output register. The divider cell chain sets the depth.
// Every command takes the same path, so results leave in input order.
// Reset clears all valid flags; the pipeline comes up empty.
// When the receiver stalls the whole pipeline holds; one input word is
// still taken into a skid register, after which o_ready drops until the
// pipeline moves again.
// ---------------------------------------------------------------------------
`include "complex_arithmetic_unit_macros.svh"

module complex_arithmetic_unit
    import cau_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [CMD_W-1:0]            i_command,
    input  logic signed [WORD_BITS-1:0] i_a_real,
    input  logic signed [WORD_BITS-1:0] i_a_imag,
    input  logic signed [WORD_BITS-1:0] i_b_real,
    input  logic signed [WORD_BITS-1:0] i_b_imag,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [WORD_BITS-1:0] o_result_real,
    output logic signed [WORD_BITS-1:0] o_result_imag,
    output logic                        o_divide_by_zero,
    output logic                        o_overflow
);

    logic  adv;
    logic  in_fire;
    t_op   in_op;
    t_op   front_op;
    logic  r_skid_v;
    t_op   r_skid;

    logic  v_chain [QB+1];
    t_lane l_chain [QB+1];

    logic                        r_out_v;
    logic signed [WORD_BITS-1:0] r_re, r_im;
    logic                        r_dz, r_ovf;
    logic signed [WORD_BITS-1:0] n_re, n_im;
    logic                        n_dz, n_ovf;
    t_fin                        f_re, f_im;
    t_lane                       last;

    assign adv     = !r_out_v || i_ready;
    assign o_ready = !r_skid_v;
    assign in_fire = i_valid && o_ready;

    assign in_op.cmd    = i_command;
    assign in_op.a_real = i_a_real;
    assign in_op.a_imag = i_a_imag;
    assign in_op.b_real = i_b_real;
    assign in_op.b_imag = i_b_imag;
    assign front_op     = r_skid_v ? r_skid : in_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (adv) begin
            r_skid_v <= 1'b0;
        end else if (in_fire) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!adv && in_fire) begin
            r_skid <= in_op;
        end
    end

    cau_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_skid_v || in_fire),
        .i_op    (front_op),
        .o_valid (v_chain[0]),
        .o_lane  (l_chain[0])
    );

    for (genvar g = 0; g < QB; g++) begin : g_cell
        cau_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (v_chain[g]),
            .i_lane  (l_chain[g]),
            .o_valid (v_chain[g+1]),
            .o_lane  (l_chain[g+1])
        );
    end

    assign last = l_chain[QB];

    always_comb begin
        f_re = f_finish(last.re_neg, last.re_sat ? '1 : MAG_W'(last.re_nq));
        f_im = f_finish(last.im_neg, last.im_sat ? '1 : MAG_W'(last.im_nq));
        if (!last.is_div) begin
            n_re  = last.re;
            n_im  = last.im;
            n_dz  = 1'b0;
            n_ovf = last.ovf;
        end else if (last.dz) begin
            n_re  = '0;
            n_im  = '0;
            n_dz  = 1'b1;
            n_ovf = 1'b0;
        end else begin
            n_re  = f_re.val;
            n_im  = f_im.val;
            n_dz  = 1'b0;
            n_ovf = f_re.ovf | f_im.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= v_chain[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_re  <= n_re;
            r_im  <= n_im;
            r_dz  <= n_dz;
            r_ovf <= n_ovf;
        end
    end

    assign o_valid          = r_out_v;
    assign o_result_real    = r_re;
    assign o_result_imag    = r_im;
    assign o_divide_by_zero = r_dz;
    assign o_overflow       = r_ovf;

    `CAU_ASSERT_NOW(a_dz_zero, i_clk, i_rst_n, o_valid && o_divide_by_zero, (o_result_real == '0) && (o_result_imag == '0) && !o_overflow, "divide by zero word not cleared")
    `CAU_ASSERT_NEXT(a_skid_fill, i_clk, i_rst_n, in_fire && !adv, r_skid_v, "stalled input word lost")
    `CAU_ASSERT_NEXT(a_skid_drain, i_clk, i_rst_n, adv && r_skid_v, !r_skid_v, "skid word not drained")

endmodule
